FILE: design/assert_macros.svh
// Assertion macros for the design files (used by lcdw_back).
// No dependencies; assertions compile away when ASSERT_OFF is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rstn, prop, msg)

`define ASSERT_NEVER(label, clk, rstn, cond, msg)

`endif

`endif

FILE: design/lcdw_pkg.sv
// Shared types and constants for the serial LCD write framer.
// No dependencies.
package lcdw_pkg;

    localparam logic [1:0] KIND_CMD    = 2'd0;
    localparam logic [1:0] KIND_NIBBLE = 2'd1;
    localparam logic [1:0] KIND_BYTE   = 2'd2;

    localparam logic [7:0] HDR_CMD   = 8'h80;
    localparam logic [7:0] HDR_WRITE = 8'ha0;

    localparam int KIND_W = 2;
    localparam int ADDR_FIELD_W = 6;
    localparam int DATA_W = 8;

    typedef struct packed {
        logic empty;
        logic full;
    } lcdw_q_stat_t;

endpackage

FILE: design/lcdw_front.sv
// Front end: accepts requests, decodes the kind and builds a left-aligned frame.
// Depends on lcdw_pkg.
module lcdw_front
    import lcdw_pkg::*;
#(
    parameter int ADDR_BITS = 6,
    parameter int FRAME_W   = ADDR_BITS + 11,
    parameter int LEN_W     = $clog2(FRAME_W + 1)
) (
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [KIND_W-1:0]       kind,
    input  logic [ADDR_FIELD_W-1:0] address,
    input  logic [DATA_W-1:0]       data_value,
    input  lcdw_q_stat_t            q_stat,
    output logic                    push,
    output logic [LEN_W+FRAME_W-1:0] push_data
);

    logic [FRAME_W-1:0] frame;
    logic [LEN_W-1:0]   len;
    logic [ADDR_BITS-1:0] addr_ext;
    logic               known;

    assign addr_ext = ADDR_BITS'(address);

    always_comb begin
        frame = '0;
        len   = '0;
        known = 1'b1;
        case (kind)
            KIND_CMD: begin
                frame[FRAME_W-1 -: 4] = HDR_CMD[7:4];
                frame[FRAME_W-5 -: 8] = data_value;
                len = LEN_W'(12);
            end
            KIND_NIBBLE: begin
                frame[FRAME_W-1 -: 3]         = HDR_WRITE[7:5];
                frame[FRAME_W-4 -: ADDR_BITS] = addr_ext;
                frame[FRAME_W-4-ADDR_BITS -: 4] = data_value[3:0];
                len = LEN_W'(ADDR_BITS + 7);
            end
            KIND_BYTE: begin
                frame[FRAME_W-1 -: 3]         = HDR_WRITE[7:5];
                frame[FRAME_W-4 -: ADDR_BITS] = addr_ext;
                frame[FRAME_W-4-ADDR_BITS -: 8] = data_value;
                len = LEN_W'(ADDR_BITS + 11);
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // unused kind is taken and dropped
    assign s_ready   = !q_stat.full;
    assign push      = s_valid && s_ready && known;
    assign push_data = {len, frame};

endmodule

FILE: design/lcdw_fifo.sv
// Small register queue that decouples request decode from serialization.
// Depends on lcdw_pkg.
module lcdw_fifo
    import lcdw_pkg::*;
#(
    parameter int WIDTH = 22,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output lcdw_q_stat_t     q_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + AW'(1);
        end
        return r;
    endfunction

    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == CW'(DEPTH));

endmodule

FILE: design/lcdw_back.sv
// Back end: shifts queued frames out MSB first, one bit per transfer, marks the last bit.
// Depends on lcdw_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lcdw_back
    import lcdw_pkg::*;
#(
    parameter int FRAME_W = 17,
    parameter int LEN_W   = $clog2(FRAME_W + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [LEN_W+FRAME_W-1:0] head,
    input  lcdw_q_stat_t             q_stat,
    output logic                     pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_bit,
    output logic                     m_last
);

    logic               active_reg, active_next;
    logic [FRAME_W-1:0] shift_reg, shift_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic               valid_reg, valid_next;
    logic               bit_reg, bit_next;
    logic               last_reg, last_next;
    logic               load_ok;
    logic [FRAME_W-1:0] head_frame;
    logic [LEN_W-1:0]   head_len;

    assign head_frame = head[FRAME_W-1:0];
    assign head_len   = head[LEN_W+FRAME_W-1:FRAME_W];
    assign load_ok    = !valid_reg || m_ready;
    assign pop        = load_ok && !active_reg && !q_stat.empty;

    always_comb begin
        active_next = active_reg;
        shift_next  = shift_reg;
        cnt_next    = cnt_reg;
        valid_next  = valid_reg;
        bit_next    = bit_reg;
        last_next   = last_reg;
        if (load_ok) begin
            valid_next = 1'b0;
            if (active_reg) begin
                valid_next  = 1'b1;
                bit_next    = shift_reg[FRAME_W-1];
                last_next   = (cnt_reg == LEN_W'(1));
                shift_next  = shift_reg << 1;
                cnt_next    = cnt_reg - LEN_W'(1);
                active_next = (cnt_reg != LEN_W'(1));
            end else if (!q_stat.empty) begin
                valid_next  = 1'b1;
                bit_next    = head_frame[FRAME_W-1];
                last_next   = (head_len == LEN_W'(1));
                shift_next  = head_frame << 1;
                cnt_next    = head_len - LEN_W'(1);
                active_next = (head_len != LEN_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        cnt_reg   <= cnt_next;
        bit_reg   <= bit_next;
        last_reg  <= last_next;
    end

    assign m_valid = valid_reg;
    assign m_bit   = bit_reg;
    assign m_last  = last_reg;

    `ASSERT_NEVER(a_active_cnt, aclk, aresetn, active_reg && (cnt_reg == '0),
                  "active with no bits left")
    `ASSERT_NEVER(a_pop_empty, aclk, aresetn, pop && q_stat.empty, "pop from empty queue")
    `ASSERT_CLK(a_cnt_step, aclk, aresetn,
                (load_ok && active_reg && (cnt_reg > LEN_W'(1))) |=>
                (active_reg && (cnt_reg == $past(cnt_reg) - LEN_W'(1))),
                "bit count did not step")

endmodule

FILE: design/lcd_controller_serial_write_framer.sv
// Serial write framer for a three-wire segment LCD controller. Each request on the
// s_ channel (tuser = kind: 0 command, 1 nibble write, 2 byte write; kind 3 is taken and
// dropped) becomes a frame of bits on the m_ channel, MSB first, one bit per transfer,
// with tlast on the final bit so chip select can be released after it. Frames are
// 12 bits (command), ADDRESS_BITS+7 (nibble) or ADDRESS_BITS+11 (byte). The output
// sustains one bit per clock while m_tready is held high. A two-entry queue lets the
// next request be accepted while the current frame is still shifting out.
// Depends on lcdw_pkg, lcdw_front, lcdw_fifo and lcdw_back.
module lcd_controller_serial_write_framer
    import lcdw_pkg::*;
#(
    parameter int ADDRESS_BITS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] address, [13:6] data_value, [15:14] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] serial_bit, [7:1] zero
    output logic        m_tlast
);

    localparam int FRAME_W = ADDRESS_BITS + 11;
    localparam int LEN_W   = $clog2(FRAME_W + 1);
    localparam int Q_W     = LEN_W + FRAME_W;

    lcdw_q_stat_t   q_stat;
    logic           push;
    logic           pop;
    logic [Q_W-1:0] push_data;
    logic [Q_W-1:0] head;
    logic           m_bit;

    lcdw_front #(
        .ADDR_BITS (ADDRESS_BITS),
        .FRAME_W   (FRAME_W),
        .LEN_W     (LEN_W)
    ) u_front (
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .kind       (s_tuser),
        .address    (s_tdata[5:0]),
        .data_value (s_tdata[13:6]),
        .q_stat     (q_stat),
        .push       (push),
        .push_data  (push_data)
    );

    lcdw_fifo #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    lcdw_back #(
        .FRAME_W (FRAME_W),
        .LEN_W   (LEN_W)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .q_stat  (q_stat),
        .pop     (pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_bit   (m_bit),
        .m_last  (m_tlast)
    );

    assign m_tdata = {7'b0, m_bit};

endmodule

FILE: tb/sv/lcdw_frame_checker.sv
`timescale 1ns / 100ps
// Frame checker for the serial LCD write framer: predicts the bit frame of each accepted
// request and compares every output transfer against it. Depends on lcdw_pkg.
module lcdw_frame_checker
    import lcdw_pkg::*;
#(
    parameter int ADDRESS_BITS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] address, [13:6] data_value, [15:14] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [0] serial_bit, [7:1] zero
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_bits
);

    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic serial_bit;
        logic last;
    } wire_bit_t;

    wire_bit_t expected_bits[$];
    wire_bit_t want;
    int        bit_index;

    initial begin
        fail_count   = 0;
        pending_bits = 0;
        bit_index    = 0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_REPORTS) begin
            $display("[%0t] mismatch at output bit %0d: %s", $realtime, bit_index, msg);
        end
        fail_count++;
    endtask

    // MSB-first frame: header, address (zero above the field width), data bits
    task automatic append_frame(input logic [KIND_W-1:0] kind,
                                input logic [ADDR_FIELD_W-1:0] addr,
                                input logic [DATA_W-1:0] data);
        logic        bits[$];
        logic [31:0] addr_ext;
        wire_bit_t   b;
        int          i;
        int          data_top;
        addr_ext = 32'(addr);
        data_top = (kind == KIND_NIBBLE) ? 3 : 7;
        case (kind)
            KIND_CMD: begin
                for (i = 7; i >= 4; i--) bits.push_back(HDR_CMD[i]);
                for (i = 7; i >= 0; i--) bits.push_back(data[i]);
            end
            KIND_NIBBLE, KIND_BYTE: begin
                for (i = 7; i >= 5; i--) bits.push_back(HDR_WRITE[i]);
                for (i = ADDRESS_BITS - 1; i >= 0; i--) bits.push_back(addr_ext[i]);
                for (i = data_top; i >= 0; i--) bits.push_back(data[i]);
            end
            default: begin
                // unused kind: dropped, nothing sent
            end
        endcase
        for (i = 0; i < bits.size(); i++) begin
            b.serial_bit = bits[i];
            b.last       = (i == bits.size() - 1);
            expected_bits.push_back(b);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_bits.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                append_frame(s_tuser, s_tdata[ADDR_FIELD_W-1:0],
                             s_tdata[ADDR_FIELD_W +: DATA_W]);
            end
            if (m_tvalid && m_tready) begin
                if (expected_bits.size() == 0) begin
                    report_mismatch($sformatf("unexpected transfer, bit %b last %b",
                                              m_tdata[0], m_tlast));
                end else begin
                    want = expected_bits.pop_front();
                    if (m_tdata[0] !== want.serial_bit) begin
                        report_mismatch($sformatf("serial_bit %b, expected %b",
                                                  m_tdata[0], want.serial_bit));
                    end
                    if (m_tlast !== want.last) begin
                        report_mismatch($sformatf("last %b, expected %b",
                                                  m_tlast, want.last));
                    end
                end
                bit_index++;
            end
        end
        pending_bits = expected_bits.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the serial LCD write framer testbench: clock, reset, request stimulus, output
// back-pressure, watchdog and verdict. Depends on lcdw_pkg and lcdw_frame_checker.
module testbench;
    import lcdw_pkg::*;

    localparam int ADDRESS_BITS = 6;
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_PER_PHASE = 63;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int SEND_IDLE[4]  = '{0, 77, 0, 28};
    localparam int RECV_STALL[4] = '{0, 0, 77, 28};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    int fail_count;
    int pending_bits;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    lcd_controller_serial_write_framer #(
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    lcdw_frame_checker #(
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending_bits(pending_bits)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("lcd_controller_serial_write_framer test failed");
            $finish;
        end
    end

    // valid stays high into the next request unless an idle cycle is drawn
    task automatic send_request(input logic [1:0] kind, input logic [5:0] addr,
                                input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, data, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    initial begin
        int          phase;
        int          sent;
        logic [1:0]  kind;
        logic [5:0]  addr;
        logic [7:0]  data;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(KIND_CMD,    6'd0,  8'h00);
        send_request(KIND_CMD,    6'd63, 8'hff);
        send_request(KIND_CMD,    6'd21, 8'ha5);
        send_request(KIND_NIBBLE, 6'd0,  8'h00);
        send_request(KIND_NIBBLE, 6'd63, 8'hff);
        send_request(KIND_NIBBLE, 6'd42, 8'hf5);
        send_request(KIND_NIBBLE, 6'd21, 8'h0a);
        send_request(KIND_BYTE,   6'd0,  8'h00);
        send_request(KIND_BYTE,   6'd63, 8'hff);
        send_request(KIND_BYTE,   6'd42, 8'h5a);
        send_request(KIND_BYTE,   6'd21, 8'ha5);
        send_request(KIND_UNUSED, 6'd63, 8'hff);
        send_request(KIND_CMD,    6'd0,  8'h01);
        send_request(KIND_UNUSED, 6'd0,  8'h00);
        send_request(KIND_BYTE,   6'd1,  8'h80);
        send_request(KIND_NIBBLE, 6'd32, 8'h08);

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct = SEND_IDLE[phase];
            stall_pct     = RECV_STALL[phase];
            sent = 0;
            while (sent < RANDOM_PER_PHASE) begin
                if ($urandom_range(15) == 0) begin
                    kind = KIND_UNUSED;
                end else begin
                    case ($urandom_range(2))
                        0:       kind = KIND_CMD;
                        1:       kind = KIND_NIBBLE;
                        default: kind = KIND_BYTE;
                    endcase
                end
                addr = ($urandom_range(7) == 0) ? {6{$urandom_range(1) == 1}}
                                                : 6'($urandom_range(63));
                data = ($urandom_range(7) == 0) ? {8{$urandom_range(1) == 1}}
                                                : 8'($urandom_range(255));
                send_request(kind, addr, data);
                if (kind != KIND_UNUSED) sent++;
            end
        end
        s_tvalid <= 1'b0;

        @(negedge aclk);
        while (pending_bits != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("lcd_controller_serial_write_framer test passed");
        end else begin
            $display("lcd_controller_serial_write_framer test failed");
        end
        $finish;
    end

endmodule

FILE: lcd_controller_serial_write_framer.f
+incdir+design
design/lcdw_pkg.sv
design/lcdw_front.sv
design/lcdw_fifo.sv
design/lcdw_back.sv
design/lcd_controller_serial_write_framer.sv
tb/sv/lcdw_frame_checker.sv
tb/sv/testbench.sv
